/* src/lba_pkg.sv */
package lba_pkg;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOSPACE  = 2'd2;
    localparam logic [1:0] ST_BADHDL   = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [7:0] NULL_LINK = 8'hFF;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_HSCAN  = 8'b0000_0010,
        S_BSCAN  = 8'b0000_0100,
        S_BLINK  = 8'b0000_1000,
        S_FREAD  = 8'b0001_0000,
        S_FWALK  = 8'b0010_0000,
        S_FFREE  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

endpackage

/* src/linked_block_allocator.sv */
// Allocate: the handle scan (S_HSCAN) checks one entry a cycle, then the block scan (S_BSCAN)
// checks one block a cycle, stopping in S_BLINK to write the link of each chained block; a
// refused allocate goes from S_HSCAN straight to S_DONE, which registers the o_done strobe.
// Free runs S_FREAD, then S_FWALK and S_FFREE per chain block; a bad handle ends after S_FREAD.
// Throughput: one request at a time; busy falls in the cycle that carries the result strobe.
// Reset: synchronous active-low i_rst_n clears busy marks (reserved blocks set), entry used
// bits and counters at once; links and entry fields are never read before they are written.
// The receiver cannot stall: o_done marks the single result cycle.
module linked_block_allocator #(
    parameter int BLOCK_BYTES     = 512,
    parameter int TOTAL_BLOCKS    = 128,
    parameter int HANDLE_ENTRIES  = 128,
    parameter int RESERVED_BLOCKS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [16:0] i_byte_count,
    input  logic [6:0]  i_free_handle,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [6:0]  o_granted_handle,
    output logic [16:0] o_granted_bytes,
    output logic [6:0]  o_free_blocks,
    output logic [7:0]  o_alloc_count
);
    localparam int BW  = (TOTAL_BLOCKS > 1) ? $clog2(TOTAL_BLOCKS) : 1;
    localparam int HW  = (HANDLE_ENTRIES > 1) ? $clog2(HANDLE_ENTRIES) : 1;
    localparam int CW  = $clog2(TOTAL_BLOCKS + 1);
    localparam int HCW = $clog2(HANDLE_ENTRIES + 1);
    localparam int DATA_BLOCKS = (TOTAL_BLOCKS > RESERVED_BLOCKS) ?
                                 TOTAL_BLOCKS - RESERVED_BLOCKS : 0;
    localparam int SH  = $clog2(BLOCK_BYTES);

    lba_pkg::t_state r_state, n_state;

    logic [TOTAL_BLOCKS-1:0]   r_busy;
    logic [HANDLE_ENTRIES-1:0] r_used;

    logic [CW-1:0]  r_used_blocks;
    logic [HCW-1:0] r_live;
    logic           r_op;
    logic [17:0]    r_nblk;
    logic [CW-1:0]  r_got;
    logic [HW:0]    r_h;
    logic [BW:0]    r_i;
    logic [BW-1:0]  r_prev;
    logic [CW-1:0]  r_k;
    logic [CW-1:0]  r_flen;
    logic [1:0]     r_st;
    logic [HW-1:0]  r_gh;

    // link memory
    logic           l_we;
    logic [BW-1:0]  l_waddr, l_raddr;
    logic [7:0]     l_wdata, l_rdata;

    // entry first-block and length memories
    logic           e_first_we, e_len_we;
    logic [BW-1:0]  e_first_rdata;
    logic [CW-1:0]  e_len_rdata;
    logic [HW-1:0]  w_fh;

    assign w_fh = HW'(i_free_handle);

    lba_block_ram #(.DEPTH(TOTAL_BLOCKS), .AW(BW), .DW(8)) u_link (
        .i_clk  (i_clk),
        .i_we   (l_we),
        .i_waddr(l_waddr),
        .i_wdata(l_wdata),
        .i_raddr(l_raddr),
        .o_rdata(l_rdata)
    );

    logic [BW-1:0] w_ib;
    logic [HW-1:0] w_hb;
    assign w_ib = r_i[BW-1:0];
    assign w_hb = r_h[HW-1:0];

    lba_block_ram #(.DEPTH(HANDLE_ENTRIES), .AW(HW), .DW(BW)) u_first (
        .i_clk  (i_clk),
        .i_we   (e_first_we),
        .i_waddr(r_gh),
        .i_wdata(w_ib),
        .i_raddr(w_fh),
        .o_rdata(e_first_rdata)
    );

    lba_block_ram #(.DEPTH(HANDLE_ENTRIES), .AW(HW), .DW(CW)) u_len (
        .i_clk  (i_clk),
        .i_we   (e_len_we),
        .i_waddr(r_gh),
        .i_wdata(r_got),
        .i_raddr(w_fh),
        .o_rdata(e_len_rdata)
    );

    logic [17:0] w_nblk;
    logic [CW-1:0] w_freeb;
    assign w_nblk = (i_byte_count == '0) ? 18'd1 :
                    18'((({1'b0, i_byte_count}) + 18'(BLOCK_BYTES - 1)) >> SH);
    assign w_freeb = (r_used_blocks <= CW'(DATA_BLOCKS)) ?
                     CW'(DATA_BLOCKS) - r_used_blocks : '0;

    assign busy = !(r_state == lba_pkg::S_IDLE);

    always_comb begin
        n_state    = r_state;
        l_we       = 1'b0;
        l_waddr    = r_prev;
        l_wdata    = lba_pkg::NULL_LINK;
        l_raddr    = r_prev;
        e_first_we = 1'b0;
        e_len_we   = 1'b0;
        unique case (r_state)
            lba_pkg::S_IDLE:  if (start) n_state = (i_opcode == lba_pkg::OP_FREE) ?
                                  lba_pkg::S_FREAD : lba_pkg::S_HSCAN;
            lba_pkg::S_HSCAN: begin
                if (r_st != lba_pkg::ST_OK) n_state = lba_pkg::S_DONE;
                else if (!r_used[w_hb]) n_state = lba_pkg::S_BSCAN;
                else if (r_h == (HW+1)'(HANDLE_ENTRIES - 1)) n_state = lba_pkg::S_DONE;
            end
            lba_pkg::S_BSCAN: begin
                if (r_i >= (BW+1)'(TOTAL_BLOCKS) || 18'(r_got) == r_nblk) begin
                    n_state  = lba_pkg::S_DONE;
                    e_len_we = 1'b1;
                end else if (!r_busy[w_ib]) begin
                    l_we    = 1'b1;
                    l_waddr = w_ib;
                    l_wdata = lba_pkg::NULL_LINK;
                    if (r_got == '0) e_first_we = 1'b1;
                    else n_state = lba_pkg::S_BLINK;
                end
            end
            lba_pkg::S_BLINK: begin
                l_we    = 1'b1;
                l_waddr = r_prev;
                l_wdata = 8'(r_i - 1'b1);
                n_state = lba_pkg::S_BSCAN;
            end
            lba_pkg::S_FREAD: begin
                if (r_st != lba_pkg::ST_OK || e_len_rdata == '0) n_state = lba_pkg::S_DONE;
                else n_state = lba_pkg::S_FWALK;
            end
            lba_pkg::S_FWALK: begin
                l_raddr = r_prev;
                n_state = lba_pkg::S_FFREE;
            end
            lba_pkg::S_FFREE: begin
                l_we    = 1'b1;
                l_waddr = r_prev;
                l_wdata = lba_pkg::NULL_LINK;
                if (r_k == CW'(1) || l_rdata >= 8'(TOTAL_BLOCKS)) n_state = lba_pkg::S_DONE;
                else n_state = lba_pkg::S_FWALK;
            end
            lba_pkg::S_DONE:  n_state = lba_pkg::S_IDLE;
            default:          n_state = lba_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= lba_pkg::S_IDLE;
            r_used        <= '0;
            r_used_blocks <= '0;
            r_live        <= '0;
            o_done        <= 1'b0;
            for (int b = 0; b < TOTAL_BLOCKS; b++) r_busy[b] <= (b < RESERVED_BLOCKS);
        end else begin
            r_state <= n_state;
            o_done  <= 1'b0;
            unique case (r_state)
                lba_pkg::S_IDLE: if (start) begin
                    r_op  <= i_opcode;
                    r_nblk <= w_nblk;
                    r_got <= '0;
                    r_h   <= '0;
                    r_i   <= (BW+1)'(RESERVED_BLOCKS);
                    r_gh  <= '0;
                    r_st  <= lba_pkg::ST_OK;
                    if (i_opcode == lba_pkg::OP_ALLOC) begin
                        if (r_live >= HCW'(HANDLE_ENTRIES)) r_st <= lba_pkg::ST_FULL;
                        else if (18'(w_freeb) < w_nblk) r_st <= lba_pkg::ST_NOSPACE;
                    end else begin
                        if (32'(i_free_handle) >= HANDLE_ENTRIES || !r_used[w_fh]) begin
                            r_st <= lba_pkg::ST_BADHDL;
                        end else begin
                            r_gh <= w_fh;
                        end
                    end
                end
                lba_pkg::S_HSCAN: if (r_st == lba_pkg::ST_OK) begin
                    if (!r_used[w_hb]) r_gh <= w_hb;
                    else if (r_h == (HW+1)'(HANDLE_ENTRIES - 1)) r_st <= lba_pkg::ST_FULL;
                    else r_h <= r_h + 1'b1;
                end
                lba_pkg::S_BSCAN: begin
                    if (r_i >= (BW+1)'(TOTAL_BLOCKS) || 18'(r_got) == r_nblk) begin
                        r_used[r_gh]   <= 1'b1;
                        r_used_blocks  <= r_used_blocks + r_got;
                        r_live         <= r_live + 1'b1;
                    end else begin
                        if (!r_busy[w_ib]) begin
                            r_busy[w_ib] <= 1'b1;
                            if (r_got == '0) r_prev <= w_ib;
                            r_got <= r_got + 1'b1;
                        end
                        r_i <= r_i + 1'b1;
                    end
                end
                lba_pkg::S_BLINK: r_prev <= BW'(r_i - 1'b1);
                // entry memories hold the chain head and length of the accepted handle
                lba_pkg::S_FREAD: if (r_st == lba_pkg::ST_OK) begin
                    r_prev <= e_first_rdata;
                    r_k    <= e_len_rdata;
                    r_flen <= e_len_rdata;
                    if (e_len_rdata == '0) begin
                        r_used[r_gh] <= 1'b0;
                        r_live       <= r_live - 1'b1;
                    end
                end
                lba_pkg::S_FWALK: ;
                lba_pkg::S_FFREE: begin
                    r_busy[r_prev] <= 1'b0;
                    r_prev <= BW'(l_rdata);
                    r_k    <= r_k - 1'b1;
                    if (r_k == CW'(1) || l_rdata >= 8'(TOTAL_BLOCKS)) begin
                        r_used[r_gh]  <= 1'b0;
                        r_live        <= r_live - 1'b1;
                        r_used_blocks <= (r_used_blocks >= r_flen) ?
                                         r_used_blocks - r_flen : '0;
                    end
                end
                lba_pkg::S_DONE: o_done <= 1'b1;
                default: ;
            endcase
        end
    end

    // result fields are taken from the registers settled by S_DONE
    always_ff @(posedge i_clk) begin
        if (r_state == lba_pkg::S_DONE) begin
            o_status         <= r_st;
            o_free_blocks    <= 7'(w_freeb);
            o_alloc_count    <= 8'(r_live);
            if (r_st == lba_pkg::ST_OK && r_op == lba_pkg::OP_ALLOC) begin
                o_granted_handle <= 7'(r_gh);
                o_granted_bytes  <= 17'(32'(r_got) << SH);
            end else begin
                o_granted_handle <= '0;
                o_granted_bytes  <= '0;
            end
        end
    end
endmodule

/* src/lba_block_ram.sv */
module lba_block_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* src/lba_checker.sv */
module lba_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [1:0] o_status,
    input logic [6:0] o_granted_handle,
    input logic [16:0] o_granted_bytes
);
    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy)) else $error("result without work");
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result repeated");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != lba_pkg::ST_OK) |->
        (o_granted_handle == '0 && o_granted_bytes == '0))
        else $error("failed request granted");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("start not taken");
endmodule

bind linked_block_allocator lba_checker u_lba_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .o_done(o_done),
    .o_status(o_status), .o_granted_handle(o_granted_handle),
    .o_granted_bytes(o_granted_bytes)
);
